[rtl/ppu_pkg.sv]
// Shared types, constants and helpers for the particle pool update unit.
`default_nettype none
package ppu_pkg;

	localparam int SLOTS     = 8;
	localparam int FRAC_BITS = 8;
	localparam int MAX_RES   = 8;
	localparam int NRES      = (SLOTS < MAX_RES) ? SLOTS : MAX_RES;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W     = 32;
	localparam int VEL_W     = 16;
	localparam int PIX_W     = 16;
	localparam int LIFE_W    = 8;
	localparam int COLOR_W   = 2;
	localparam int GRAV_W    = 8;
	localparam int OSLOT_W   = 3;

	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 8'd12;
	localparam logic [LIFE_W-1:0] BLINK_BELOW   = 8'd4;

	localparam logic MODE_SPAWN = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPAWN,
		ST_TICK
	} ppu_state_t;

	typedef struct packed {
		logic              capture;
		logic              spawn;
		logic              step;
		logic              report;
		logic              last;
		logic [SLOT_W-1:0] idx;
	} ppu_cmd_t;

	typedef struct packed {
		logic s1_free;
	} ppu_sts_t;

	// position over 2^FRAC_BITS, truncated toward zero, low bits
	function automatic logic [PIX_W-1:0] to_screen(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] sh;
		logic             rnd;
		begin
			sh  = POS_W'($signed(p) >>> FRAC_BITS);
			rnd = p[POS_W-1] & (|p[FRAC_BITS-1:0]);
			to_screen = sh[PIX_W-1:0] + {{(PIX_W-1){1'b0}}, rnd};
		end
	endfunction

endpackage
`default_nettype wire

[rtl/ppu_ctrl.sv]
// Sequencer for the particle pool: accepts items and issues spawn and per-slot steps.
`default_nettype none
module ppu_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               mode,
	input  ppu_pkg::ppu_sts_t sts,
	output ppu_pkg::ppu_cmd_t cmd,
	output logic              in_stall
);
	import ppu_pkg::*;

	ppu_state_t        state_q, state_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic              idx_end;

	assign idx_end = (idx_q == SLOT_W'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		cmd         = '0;
		cmd.idx     = idx_q;
		cmd.report  = (int'(idx_q) < NRES);
		cmd.last    = (idx_q == SLOT_W'(NRES - 1));
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				idx_d    = '0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = (mode == MODE_TICK) ? ST_TICK : ST_SPAWN;
				end
			end
			ST_SPAWN: begin
				if (sts.s1_free) begin
					cmd.spawn = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (sts.s1_free) begin
					cmd.step = 1'b1;
					idx_d    = idx_q + 1'b1;
					if (idx_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/ppu_dp.sv]
// Datapath: slot storage, Euler update, result stage and output register.
`default_nettype none
module ppu_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  ppu_pkg::ppu_cmd_t                cmd,
	output ppu_pkg::ppu_sts_t                sts,
	input  wire                              cfg_valid,
	input  wire  [ppu_pkg::GRAV_W-1:0]       cfg_gravity,
	input  wire  signed [ppu_pkg::PIX_W-1:0] pos_x,
	input  wire  signed [ppu_pkg::PIX_W-1:0] pos_y,
	input  wire  signed [ppu_pkg::VEL_W-1:0] vel_x,
	input  wire  signed [ppu_pkg::VEL_W-1:0] vel_y,
	input  wire  [ppu_pkg::LIFE_W-1:0]       lifetime,
	input  wire  [ppu_pkg::COLOR_W-1:0]      palette_code,
	input  wire                              paused,
	input  wire                              frozen,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [ppu_pkg::OSLOT_W-1:0]      slot,
	output logic                             alive,
	output logic signed [ppu_pkg::PIX_W-1:0] screen_x,
	output logic signed [ppu_pkg::PIX_W-1:0] screen_y,
	output logic                             hidden,
	output logic [ppu_pkg::COLOR_W-1:0]      color_code,
	output logic                             accepted,
	output logic                             last
);
	import ppu_pkg::*;

	// captured item
	logic [PIX_W-1:0]   pos_x_q, pos_y_q;
	logic [VEL_W-1:0]   vel_x_q, vel_y_q;
	logic [LIFE_W-1:0]  lifetime_q;
	logic [COLOR_W-1:0] palette_q;
	logic               paused_q, frozen_q;
	logic [GRAV_W-1:0]  gravity_q;

	// slot storage
	logic [POS_W-1:0]   x_q     [SLOTS];
	logic [POS_W-1:0]   y_q     [SLOTS];
	logic [VEL_W-1:0]   vx_q    [SLOTS];
	logic [VEL_W-1:0]   vy_q    [SLOTS];
	logic [LIFE_W-1:0]  life_q  [SLOTS];
	logic [COLOR_W-1:0] color_q [SLOTS];

	// result stage
	logic               s1_vld_q;
	logic [SLOT_W-1:0]  slot_s1;
	logic               alive_s1, tick_s1, paused_s1, last_s1;
	logic [POS_W-1:0]   x_s1, y_s1;
	logic [LIFE_W-1:0]  life_s1;
	logic [COLOR_W-1:0] color_s1;

	// output register
	logic               out_vld_q;
	logic [OSLOT_W-1:0] slot_q;
	logic               alive_q, hidden_q, accepted_q, last_q;
	logic [PIX_W-1:0]   sx_q, sy_q;
	logic [COLOR_W-1:0] color_code_q;

	logic               out_free, s1_adv, s1_load;
	logic               free_found, spawn_ok;
	logic [SLOT_W-1:0]  free_idx;
	logic               live, move;
	logic [POS_W-1:0]   nx, ny, spawn_x, spawn_y;
	logic [VEL_W-1:0]   nvy;
	logic [LIFE_W-1:0]  nlife;
	logic               blink;

	assign out_free    = !out_vld_q || !out_stall;
	assign s1_adv      = s1_vld_q && out_free;
	assign sts.s1_free = !s1_vld_q || out_free;
	assign s1_load     = cmd.spawn || (cmd.step && cmd.report);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (life_q[i] == '0) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign spawn_ok = free_found && (lifetime_q != '0);
	assign spawn_x  = {{(POS_W-PIX_W){pos_x_q[PIX_W-1]}}, pos_x_q} << FRAC_BITS;
	assign spawn_y  = {{(POS_W-PIX_W){pos_y_q[PIX_W-1]}}, pos_y_q} << FRAC_BITS;

	// Euler step of the addressed slot
	assign live  = (life_q[cmd.idx] != '0);
	assign move  = live && !paused_q && !frozen_q;
	assign nx    = x_q[cmd.idx] + {{(POS_W-VEL_W){vx_q[cmd.idx][VEL_W-1]}}, vx_q[cmd.idx]};
	assign ny    = y_q[cmd.idx] + {{(POS_W-VEL_W){vy_q[cmd.idx][VEL_W-1]}}, vy_q[cmd.idx]};
	assign nvy   = vy_q[cmd.idx] + {{(VEL_W-GRAV_W){1'b0}}, gravity_q};
	assign nlife = life_q[cmd.idx] - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				life_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				gravity_q <= cfg_gravity;
			end
			if (cmd.spawn && spawn_ok) begin
				life_q[free_idx] <= lifetime_q;
			end else if (cmd.step && move) begin
				life_q[cmd.idx] <= nlife;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_x_q    <= pos_x;
			pos_y_q    <= pos_y;
			vel_x_q    <= vel_x;
			vel_y_q    <= vel_y;
			lifetime_q <= lifetime;
			palette_q  <= palette_code;
			paused_q   <= paused;
			frozen_q   <= frozen;
		end
		if (cmd.spawn && spawn_ok) begin
			x_q[free_idx]     <= spawn_x;
			y_q[free_idx]     <= spawn_y;
			vx_q[free_idx]    <= vel_x_q;
			vy_q[free_idx]    <= vel_y_q;
			color_q[free_idx] <= palette_q;
		end else if (cmd.step && move) begin
			x_q[cmd.idx]  <= nx;
			y_q[cmd.idx]  <= ny;
			vy_q[cmd.idx] <= nvy;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s1_load) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.spawn) begin
			slot_s1   <= spawn_ok ? free_idx : '0;
			alive_s1  <= spawn_ok;
			tick_s1   <= 1'b0;
			paused_s1 <= 1'b0;
			last_s1   <= 1'b1;
			x_s1      <= spawn_x;
			y_s1      <= spawn_y;
			life_s1   <= lifetime_q;
			color_s1  <= palette_q;
		end else if (cmd.step && cmd.report) begin
			slot_s1   <= cmd.idx;
			alive_s1  <= move ? (nlife != '0) : live;
			tick_s1   <= 1'b1;
			paused_s1 <= paused_q;
			last_s1   <= cmd.last;
			x_s1      <= move ? nx : x_q[cmd.idx];
			y_s1      <= move ? ny : y_q[cmd.idx];
			life_s1   <= move ? nlife : life_q[cmd.idx];
			color_s1  <= color_q[cmd.idx];
		end
	end

	// output register
	assign blink = (life_s1 < BLINK_BELOW) && life_s1[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			slot_q       <= OSLOT_W'(slot_s1);
			alive_q      <= alive_s1;
			sx_q         <= alive_s1 ? to_screen(x_s1) : '0;
			sy_q         <= alive_s1 ? to_screen(y_s1) : '0;
			hidden_q     <= alive_s1 && tick_s1 && (paused_s1 || blink);
			color_code_q <= alive_s1 ? color_s1 : '0;
			accepted_q   <= alive_s1 && !tick_s1;
			last_q       <= last_s1;
		end
	end

	assign out_valid  = out_vld_q;
	assign slot       = slot_q;
	assign alive      = alive_q;
	assign screen_x   = sx_q;
	assign screen_y   = sy_q;
	assign hidden     = hidden_q;
	assign color_code = color_code_q;
	assign accepted   = accepted_q;
	assign last       = last_q;

endmodule
`default_nettype wire

[rtl/particle_pool_update_unit.sv]
// Top level of the particle pool update unit: sequencer plus datapath.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  mode, pos_x, pos_y, vel_x, vel_y,
//                                           lifetime, palette_code, paused, frozen
//  out      source     out_valid/out_stall  slot, alive, screen_x, screen_y,
//                                           hidden, color_code, accepted, last
//  cfg      sink       cfg_valid/cfg_ready  cfg_gravity
//
// A spawn is captured in idle, then issued from the spawn state; a tick is captured,
// then walks every slot, one slot per cycle while the result stage can take it,
// through the single update adder set. Each result passes the result stage, then the output register.
// Reset clears all slot lives and sets gravity to 12; no clearing pass.
// Stalls on out hold the output register, then the result stage, then the
// slot walk; in_stall stays high until the item's last step is issued.
`default_nettype none
module particle_pool_update_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              mode,
	input  wire  signed [ppu_pkg::PIX_W-1:0] pos_x,
	input  wire  signed [ppu_pkg::PIX_W-1:0] pos_y,
	input  wire  signed [ppu_pkg::VEL_W-1:0] vel_x,
	input  wire  signed [ppu_pkg::VEL_W-1:0] vel_y,
	input  wire  [ppu_pkg::LIFE_W-1:0]       lifetime,
	input  wire  [ppu_pkg::COLOR_W-1:0]      palette_code,
	input  wire                              paused,
	input  wire                              frozen,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [ppu_pkg::OSLOT_W-1:0]      slot,
	output logic                             alive,
	output logic signed [ppu_pkg::PIX_W-1:0] screen_x,
	output logic signed [ppu_pkg::PIX_W-1:0] screen_y,
	output logic                             hidden,
	output logic [ppu_pkg::COLOR_W-1:0]      color_code,
	output logic                             accepted,
	output logic                             last,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [ppu_pkg::GRAV_W-1:0]       cfg_gravity
);
	import ppu_pkg::*;

	ppu_cmd_t cmd;
	ppu_sts_t sts;

	assign cfg_ready = 1'b1;

	ppu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	ppu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_gravity  (cfg_gravity),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.lifetime     (lifetime),
		.palette_code (palette_code),
		.paused       (paused),
		.frozen       (frozen),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot         (slot),
		.alive        (alive),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.hidden       (hidden),
		.color_code   (color_code),
		.accepted     (accepted),
		.last         (last)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transfer");

	a_spawn_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (alive && last && !hidden))
		else $error("accepted spawn result malformed");

	a_hidden_live: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hidden) |-> alive)
		else $error("hidden flag on a dead slot");

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !alive) |->
		(screen_x == '0 && screen_y == '0 && color_code == '0 && !accepted))
		else $error("dead slot result not cleared");

endmodule
`default_nettype wire
